@@ rtl/kfli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfli_pkg
// Shared types and constants for the five-channel keyframe interpolator.
// ----------------------------------------------------------------------------
package kfli_pkg;

  localparam int NCHAN = 5;
  localparam int ACCW  = 32;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_STORE = 2'd1,
    FUNC_PLAY  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_DROPPED  = 3'd2,
    EV_STARTED  = 3'd3,
    EV_STOPPED  = 3'd4,
    EV_FINISHED = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic signed [15:0] thumb_angle;
    logic signed [15:0] index_angle;
    logic signed [15:0] middle_angle;
    logic signed [15:0] ring_angle;
    logic signed [15:0] little_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] thumb_pos;
    logic signed [15:0] index_pos;
    logic signed [15:0] middle_pos;
    logic signed [15:0] ring_pos;
    logic signed [15:0] little_pos;
    logic               playing;
    logic [2:0]         event_res;
  } out_item_t;

  // Control from sequencer to lanes
  typedef struct packed {
    logic load_cur;    // capture current-frame angle
    logic div_start;   // begin increment division
    logic step;        // add increment to accumulator
    logic set_acc;     // accumulator <- current frame angle
  } lane_ctl_t;

  function automatic logic signed [ACCW-1:0] sat32(input logic signed [ACCW:0] v);
    logic signed [ACCW-1:0] r;
    if (v > 33'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -33'sd2147483648) r = 32'sh80000000;
    else                           r = v[ACCW-1:0];
    return r;
  endfunction

endpackage

@@ rtl/kfli_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfli_lane
// One channel: accumulator, increment and a bit-serial signed divider that
// forms (next - cur) * 2^16 / steps, truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module kfli_lane (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kfli_pkg::lane_ctl_t     ctl,
  input  logic signed [15:0]      rd_angle,
  input  logic [15:0]             steps,
  output logic signed [15:0]      pos,
  output logic                    div_busy
);

  // dividend magnitude up to 17+16 = 33 bits
  localparam int DW = 33;

  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] inc_r, inc_nxt;
  logic signed [15:0] cur_r;
  logic [DW-1:0]      quo_r, quo_nxt;
  logic [16:0]        rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r;

  logic signed [16:0] diff;
  logic [16:0]        diff_mag;
  logic [17:0]        trial;
  logic [DW:0]        q_ext;
  logic signed [DW+1:0] q_sgn;

  assign diff     = 17'(rd_angle) - 17'(cur_r);
  assign diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
  assign trial    = {rem_r, quo_r[DW-1]} - {2'b00, steps};

  // signed quotient then saturate
  always_comb begin
    q_ext = {1'b0, quo_r};
    q_sgn = neg_r ? -$signed({1'b0, q_ext}) : $signed({1'b0, q_ext});
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.div_start) begin
      quo_nxt  = {diff_mag, 16'd0};
      rem_nxt  = '0;
      neg_nxt  = diff[16];
      cnt_nxt  = 6'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], quo_r[DW-1]};
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  // load the finished quotient the cycle after the divider goes idle
  assign inc_nxt = done_r ? kfli_pkg::sat32(q_sgn[32:0]) : inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
      inc_r  <= '0;
      acc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= busy_r && !busy_nxt;
      inc_r  <= inc_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    if (ctl.load_cur) cur_r <= rd_angle;
  end

  // accumulator update
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.set_acc)   acc_nxt = {rd_angle, 16'd0};
    else if (ctl.step) acc_nxt = kfli_pkg::sat32(33'(acc_r) + 33'(inc_r));
  end

  assign pos      = acc_r[31:16];
  assign div_busy = busy_r | done_r;

endmodule

@@ rtl/keyframe_linear_interpolator.sv @@
`timescale 1ns / 1ps
// Timing: an item that reads no keyframe goes through ST_OUT to the result register;
// start and segment change go first through two keyframe memory reads (ST_RD0, ST_RD1),
// a 33-step bit-serial divide run in all five lanes at once, then the quotient load.
// One item in flight: the next input transfer comes at the earliest in the cycle after
// the result transfer.
// rst_n is synchronous; keyframe memory is not cleared (only stored frames are read).
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Sequencer, keyframe memory and five parallel interpolation lanes.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator #(
  parameter int MAX_KEYFRAMES = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kfli_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kfli_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);

  localparam int FW = $clog2(MAX_KEYFRAMES + 1);
  localparam int AW = $clog2(MAX_KEYFRAMES);

  kfli_pkg::state_t state_r, state_nxt;
  logic [15:0]      steps_r;
  logic [FW-1:0]    fcnt_r, fcnt_nxt;
  logic [AW-1:0]    seg_r, seg_nxt;
  logic [15:0]      scnt_r, scnt_nxt;
  logic             play_r, play_nxt;
  logic [2:0]       ev_r, ev_nxt;
  logic             ov_r, ov_nxt;
  logic             has_nxt_r, has_nxt_nxt;
  kfli_pkg::lane_ctl_t ctl;
  logic [AW-1:0]    raddr;
  logic             rd_en;
  logic [4:0]       busy;
  logic [15:0]      eff_steps;
  logic signed [15:0] pos [5];
  logic signed [15:0] rd_ang [5];

  // keyframe memory, one row of five angles per frame
  logic [79:0] mem [MAX_KEYFRAMES];
  logic [79:0] rdata_r;
  logic        wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[fcnt_r[AW-1:0]] <= {in_data.thumb_angle, in_data.index_angle,
                                       in_data.middle_angle, in_data.ring_angle,
                                       in_data.little_angle};
    if (rd_en) rdata_r <= mem[raddr];
  end

  assign rd_ang[0] = rdata_r[79:64];
  assign rd_ang[1] = rdata_r[63:48];
  assign rd_ang[2] = rdata_r[47:32];
  assign rd_ang[3] = rdata_r[31:16];
  assign rd_ang[4] = rdata_r[15:0];

  assign eff_steps = (steps_r == 16'd0) ? 16'd1 : steps_r;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != kfli_pkg::ST_IDLE) || ov_r;

  // parallel lanes
  for (genvar c = 0; c < kfli_pkg::NCHAN; c++) begin : g_lane
    kfli_lane u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .rd_angle(rd_ang[c]),
      .steps(eff_steps), .pos(pos[c]), .div_busy(busy[c])
    );
  end

  logic in_xfer;
  logic [1:0] fn;
  assign in_xfer = in_valid && !in_stall;
  assign fn = in_data.func;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    fcnt_nxt    = fcnt_r;
    seg_nxt     = seg_r;
    scnt_nxt    = scnt_r;
    play_nxt    = play_r;
    ev_nxt      = ev_r;
    ov_nxt      = ov_r;
    has_nxt_nxt = has_nxt_r;
    ctl         = '0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    raddr       = seg_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      kfli_pkg::ST_IDLE: begin
        if (in_xfer) begin
          ev_nxt    = kfli_pkg::EV_NONE;
          state_nxt = kfli_pkg::ST_OUT;
          unique case (fn)
            kfli_pkg::FUNC_TICK: begin
              if (play_r) begin
                if (scnt_r >= eff_steps) begin
                  if (FW'(seg_r) + FW'(3) > fcnt_r) begin
                    seg_nxt  = '0;
                    play_nxt = 1'b0;
                    ev_nxt   = kfli_pkg::EV_FINISHED;
                  end else begin
                    seg_nxt   = seg_r + AW'(1);
                    scnt_nxt  = '0;
                    rd_en     = 1'b1;
                    raddr     = seg_r + AW'(1);
                    has_nxt_nxt = 1'b0;
                    state_nxt = kfli_pkg::ST_RD0;
                  end
                end else begin
                  ctl.step = 1'b1;
                  scnt_nxt = scnt_r + 16'd1;
                end
              end
            end
            kfli_pkg::FUNC_STORE: begin
              if (fcnt_r < FW'(MAX_KEYFRAMES)) begin
                wr_en    = 1'b1;
                fcnt_nxt = fcnt_r + FW'(1);
                ev_nxt   = kfli_pkg::EV_STORED;
              end else begin
                ev_nxt = kfli_pkg::EV_DROPPED;
              end
            end
            kfli_pkg::FUNC_PLAY: begin
              if (!play_r && fcnt_r > FW'(1)) begin
                seg_nxt   = '0;
                scnt_nxt  = '0;
                rd_en     = 1'b1;
                raddr     = '0;
                has_nxt_nxt = 1'b1;
                play_nxt  = 1'b1;
                state_nxt = kfli_pkg::ST_RD0;
              end else if (play_r) begin
                play_nxt = 1'b0;
                ev_nxt   = kfli_pkg::EV_STOPPED;
              end
            end
            default: ev_nxt = kfli_pkg::EV_NONE;
          endcase
        end
      end
      kfli_pkg::ST_RD0: begin
        // current frame arrives; fetch next
        ctl.load_cur = 1'b1;
        ctl.set_acc  = has_nxt_r;
        rd_en        = 1'b1;
        raddr        = seg_r + AW'(1);
        state_nxt    = kfli_pkg::ST_RD1;
      end
      kfli_pkg::ST_RD1: begin
        ctl.div_start = 1'b1;
        ev_nxt    = has_nxt_r ? kfli_pkg::EV_STARTED : kfli_pkg::EV_NONE;
        state_nxt = kfli_pkg::ST_DIV;
      end
      kfli_pkg::ST_DIV: begin
        if (busy == 5'd0) state_nxt = kfli_pkg::ST_OUT;
      end
      kfli_pkg::ST_OUT: begin
        ov_nxt    = 1'b1;
        state_nxt = kfli_pkg::ST_IDLE;
      end
      default: state_nxt = kfli_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kfli_pkg::ST_IDLE;
      steps_r   <= 16'd90;
      fcnt_r    <= '0;
      seg_r     <= '0;
      scnt_r    <= '0;
      play_r    <= 1'b0;
      ev_r      <= kfli_pkg::EV_NONE;
      ov_r      <= 1'b0;
      has_nxt_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fcnt_r    <= fcnt_nxt;
      seg_r     <= seg_nxt;
      scnt_r    <= scnt_nxt;
      play_r    <= play_nxt;
      ev_r      <= ev_nxt;
      ov_r      <= ov_nxt;
      has_nxt_r <= has_nxt_nxt;
      if (cfg_valid && cfg_ready) steps_r <= cfg_data;
    end
  end

  // result register, held while stalled
  assign out_valid          = ov_r;
  assign out_data.thumb_pos  = pos[0];
  assign out_data.index_pos  = pos[1];
  assign out_data.middle_pos = pos[2];
  assign out_data.ring_pos   = pos[3];
  assign out_data.little_pos = pos[4];
  assign out_data.playing    = play_r;
  assign out_data.event_res  = ev_r;

endmodule

@@ rtl/kfli_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfli_checker
// Port-level checks on the interpolator's handshakes and result codes.
// ----------------------------------------------------------------------------
module kfli_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input kfli_pkg::out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a result is pending, so no new transfer is taken
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // a start event always reports playing
  a_start_play: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == kfli_pkg::EV_STARTED |-> out_data.playing)
    else $error("start without playing");

  // stop and finish events report not playing
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == kfli_pkg::EV_STOPPED ||
                  out_data.event_res == kfli_pkg::EV_FINISHED) |-> !out_data.playing)
    else $error("stop while playing");

endmodule

bind keyframe_linear_interpolator kfli_checker u_kfli_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
